// ===== rtl/core/sds_pkg.sv =====
`default_nettype none

package sds_pkg;

    localparam int MAX_REQUESTS = 32;
    localparam int CYL_WIDTH    = 16;
    localparam int STORE_DEPTH  = MAX_REQUESTS + 2;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
    localparam int DC_W         = CYL_WIDTH + 1;
    localparam int KEY_W        = CYL_WIDTH + ADDR_W;
    localparam int TOTAL_W      = 22;
    localparam int TOTAL_MAX    = (1 << TOTAL_W) - 1;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = 2;

    localparam logic [REG_IDX_W-1:0] REG_DISK_CYLINDERS  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_HEAD      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SWEEP_DIRECTION = 2'd2;

    localparam logic [DC_W-1:0]      DISK_CYL_RESET = DC_W'(200);
    localparam logic [CYL_WIDTH-1:0] CYL_MAX        = {CYL_WIDTH{1'b1}};

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_TOP,
        ST_ZERO,
        ST_SCAN,
        ST_EMIT
    } sds_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/sds_ram.sv =====
`default_nettype none

module sds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 34
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/scan_disk_scheduler_unit.sv =====
`default_nettype none

// SCAN (elevator) disk scheduler. Requests are taken one per cycle on the s_ channel and
// kept in a 34-entry request memory (up to 32 requests; further ones are dropped). The
// request carrying s_batch_end closes the batch: the block writes the two endpoints
// (disk_cylinders-1 and cylinder 0) into the memory and then emits the stops on the m_
// channel in sweep order, with per-stop seek distance, running total and a final flag.
// No request is taken while a sweep runs. Each stop is found by a full pass over the
// memory through its single read port; when one side of the head is exhausted, a
// further pass runs in the opposite direction.
// Registers: 0x0 disk_cylinders, 0x4 start_head, 0x8 sweep_direction.
module scan_disk_scheduler_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sds_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [sds_pkg::PDATA_W-1:0]     pwdata,
    output logic      [sds_pkg::PDATA_W-1:0]     prdata,
    output logic                                 pready,
    // requests
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [sds_pkg::CYL_WIDTH-1:0]   s_cylinder,
    input  wire logic                            s_batch_end,
    // stops
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [sds_pkg::CYL_WIDTH-1:0]   m_served_cylinder,
    output logic      [sds_pkg::CYL_WIDTH-1:0]   m_seek_distance,
    output logic      [sds_pkg::TOTAL_W-1:0]     m_total_movement,
    output logic                                 m_final_stop
);

    import sds_pkg::*;

    sds_state_t state_reg, state_next;

    logic [DC_W-1:0]      disk_cyl_reg;
    logic [CYL_WIDTH-1:0] start_head_reg;
    logic                 sweep_dir_reg;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [ADDR_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                 phase_reg, phase_next;
    logic                 bound_valid_reg, bound_valid_next;
    logic [KEY_W-1:0]     bound_key_reg, bound_key_next;
    logic                 best_valid_reg, best_valid_next;
    logic [KEY_W-1:0]     best_key_reg, best_key_next;
    logic [CNT_W-1:0]     stops_reg, stops_next;
    logic [CYL_WIDTH-1:0] head_reg, head_next;
    logic [TOTAL_W-1:0]   sum_reg, sum_next;

    logic                 m_valid_reg, m_valid_next;
    logic [CYL_WIDTH-1:0] out_cyl_reg, out_cyl_next;
    logic [CYL_WIDTH-1:0] out_dist_reg, out_dist_next;
    logic [TOTAL_W-1:0]   out_total_reg, out_total_next;
    logic                 out_final_reg, out_final_next;

    // fsm outputs
    logic                 in_fire;
    logic                 store_ok;
    logic                 issuing;
    logic                 scan_done;
    logic                 emit_fire;
    logic                 last_stop;

    // memory port
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [CYL_WIDTH-1:0] ram_wdata;
    logic [CYL_WIDTH-1:0] ram_rdata;

    // datapath
    logic [CNT_W-1:0]     count_p1;
    logic [DC_W-1:0]      top_wide;
    logic [CYL_WIDTH-1:0] top_cyl;
    logic                 ascending;
    logic [KEY_W-1:0]     rd_key;
    logic                 is_request;
    logic                 in_upper;
    logic                 in_lower;
    logic                 cand_ok;
    logic [CYL_WIDTH-1:0] best_cyl;
    logic [CYL_WIDTH-1:0] seek_dist;
    logic [TOTAL_W:0]     sum_wide;
    logic [TOTAL_W-1:0]   sum_sat;
    logic                 cfg_wr;

    sds_ram #(
        .WIDTH (CYL_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_cyl_reg   <= DISK_CYL_RESET;
            start_head_reg <= '0;
            sweep_dir_reg  <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[REG_IDX_W+1:2])
                REG_DISK_CYLINDERS:  disk_cyl_reg   <= pwdata[DC_W-1:0];
                REG_START_HEAD:      start_head_reg <= pwdata[CYL_WIDTH-1:0];
                REG_SWEEP_DIRECTION: sweep_dir_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_IDX_W+1:2])
            REG_DISK_CYLINDERS:  prdata = PDATA_W'(disk_cyl_reg);
            REG_START_HEAD:      prdata = PDATA_W'(start_head_reg);
            REG_SWEEP_DIRECTION: prdata = PDATA_W'(sweep_dir_reg);
            default:             prdata = '0;
        endcase
    end

    // ---------------- common terms ----------------
    assign count_p1 = count_reg + CNT_W'(1);

    // top endpoint, saturated to the cylinder range
    assign top_wide = disk_cyl_reg - DC_W'(1);
    always_comb begin
        if (disk_cyl_reg == '0) begin
            top_cyl = '0;
        end else if (top_wide > DC_W'(CYL_MAX)) begin
            top_cyl = CYL_MAX;
        end else begin
            top_cyl = top_wide[CYL_WIDTH-1:0];
        end
    end

    // phase 0 follows the configured direction, phase 1 the opposite one
    assign ascending = phase_reg ^ sweep_dir_reg;

    // ties between equal cylinders are broken by memory index
    assign rd_key     = {ram_rdata, rd_idx_reg};
    assign is_request = CNT_W'(rd_idx_reg) < count_reg;
    assign in_upper   = is_request ? (ram_rdata >= start_head_reg)
                                   : (CNT_W'(rd_idx_reg) == count_reg);
    assign in_lower   = is_request ? (ram_rdata < start_head_reg)
                                   : (CNT_W'(rd_idx_reg) == count_p1);

    always_comb begin
        if (ascending) begin
            cand_ok = in_upper
                   && (!bound_valid_reg || rd_key > bound_key_reg)
                   && (!best_valid_reg  || rd_key < best_key_reg);
        end else begin
            cand_ok = in_lower
                   && (!bound_valid_reg || rd_key < bound_key_reg)
                   && (!best_valid_reg  || rd_key > best_key_reg);
        end
    end

    assign best_cyl  = best_key_reg[KEY_W-1:ADDR_W];
    assign seek_dist = (best_cyl > head_reg) ? (best_cyl - head_reg) : (head_reg - best_cyl);
    assign sum_wide  = {1'b0, sum_reg} + (TOTAL_W+1)'(seek_dist);
    assign sum_sat   = (sum_wide > (TOTAL_W+1)'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX)
                                                             : sum_wide[TOTAL_W-1:0];

    // ---------------- fsm outputs ----------------
    always_comb begin
        s_ready   = (state_reg == ST_LOAD);
        in_fire   = s_valid && s_ready;
        store_ok  = count_reg < CNT_W'(MAX_REQUESTS);
        issuing   = (state_reg == ST_SCAN) && (issue_reg <= count_p1);
        scan_done = (state_reg == ST_SCAN) && rd_valid_reg
                 && (CNT_W'(rd_idx_reg) == count_p1);
        emit_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
        last_stop = (stops_reg == count_p1);
        ram_we    = 1'b0;
        ram_waddr = count_reg[ADDR_W-1:0];
        ram_wdata = s_cylinder;
        case (state_reg)
            ST_LOAD: begin
                ram_we = in_fire && store_ok;
            end
            ST_TOP: begin
                ram_we    = 1'b1;
                ram_wdata = top_cyl;
            end
            ST_ZERO: begin
                ram_we    = 1'b1;
                ram_waddr = count_p1[ADDR_W-1:0];
                ram_wdata = '0;
            end
            default: ;
        endcase
    end

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_fire && s_batch_end) begin
                    state_next = ST_TOP;
                end
            end
            ST_TOP:  state_next = ST_ZERO;
            ST_ZERO: state_next = ST_SCAN;
            ST_SCAN: begin
                if (scan_done && (best_valid_reg || cand_ok)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    state_next = last_stop ? ST_LOAD : ST_SCAN;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // ---------------- datapath next values ----------------
    always_comb begin
        count_next       = count_reg;
        issue_next       = issue_reg;
        rd_valid_next    = issuing;
        rd_idx_next      = issue_reg[ADDR_W-1:0];
        phase_next       = phase_reg;
        bound_valid_next = bound_valid_reg;
        bound_key_next   = bound_key_reg;
        best_valid_next  = best_valid_reg;
        best_key_next    = best_key_reg;
        stops_next       = stops_reg;
        head_next        = head_reg;
        sum_next         = sum_reg;
        m_valid_next     = m_ready ? 1'b0 : m_valid_reg;
        out_cyl_next     = out_cyl_reg;
        out_dist_next    = out_dist_reg;
        out_total_next   = out_total_reg;
        out_final_next   = out_final_reg;

        if (in_fire && store_ok) begin
            count_next = count_p1;
        end

        if (state_reg == ST_ZERO) begin
            issue_next       = '0;
            phase_next       = 1'b0;
            bound_valid_next = 1'b0;
            best_valid_next  = 1'b0;
            stops_next       = '0;
            head_next        = start_head_reg;
            sum_next         = '0;
        end

        if (issuing) begin
            issue_next = issue_reg + CNT_W'(1);
        end

        if (state_reg == ST_SCAN && rd_valid_reg && cand_ok) begin
            best_valid_next = 1'b1;
            best_key_next   = rd_key;
        end

        // set exhausted: move on to the other side of the head
        if (scan_done && !(best_valid_reg || cand_ok)) begin
            phase_next       = 1'b1;
            bound_valid_next = 1'b0;
            issue_next       = '0;
        end

        if (emit_fire) begin
            m_valid_next     = 1'b1;
            out_cyl_next     = best_cyl;
            out_dist_next    = seek_dist;
            out_total_next   = sum_sat;
            out_final_next   = last_stop;
            head_next        = best_cyl;
            sum_next         = sum_sat;
            stops_next       = stops_reg + CNT_W'(1);
            bound_valid_next = 1'b1;
            bound_key_next   = best_key_reg;
            best_valid_next  = 1'b0;
            issue_next       = '0;
            if (last_stop) begin
                count_next = '0;
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LOAD;
            count_reg       <= '0;
            issue_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            phase_reg       <= 1'b0;
            bound_valid_reg <= 1'b0;
            best_valid_reg  <= 1'b0;
            stops_reg       <= '0;
            head_reg        <= '0;
            sum_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            issue_reg       <= issue_next;
            rd_valid_reg    <= rd_valid_next;
            phase_reg       <= phase_next;
            bound_valid_reg <= bound_valid_next;
            best_valid_reg  <= best_valid_next;
            stops_reg       <= stops_next;
            head_reg        <= head_next;
            sum_reg         <= sum_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        bound_key_reg <= bound_key_next;
        best_key_reg  <= best_key_next;
        out_cyl_reg   <= out_cyl_next;
        out_dist_reg  <= out_dist_next;
        out_total_reg <= out_total_next;
        out_final_reg <= out_final_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_served_cylinder = out_cyl_reg;
    assign m_seek_distance   = out_dist_reg;
    assign m_total_movement  = out_total_reg;
    assign m_final_stop      = out_final_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_REQUESTS))
        else $error("request count beyond store capacity");

    a_emit_has_best: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> best_valid_reg)
        else $error("emit without a selected stop");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire && last_stop |=> count_reg == '0 && state_reg == ST_LOAD && m_final_stop)
        else $error("final stop did not close the batch");

    a_total_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |-> sum_sat >= sum_reg)
        else $error("running total decreased");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> issue_reg <= count_reg + CNT_W'(2))
        else $error("scan address ran past the stored entries");
`endif

endmodule

`default_nettype wire
